// File: sv/psr_pkg.sv
// psr_pkg: shared constants, types and codes for the packet rate shaper
// used by the front, command queue, back and top of the shaper; no dependencies
package psr_pkg;

   localparam int QUEUE_DEPTH    = 16;
   localparam int FRAC_BITS      = 16;
   localparam int CMD_FIFO_DEPTH = 2;

   localparam int NOW_W     = 48;
   localparam int TAG_W     = 16;
   localparam int SIZE_W    = 16;
   localparam int TPB_W     = 32;
   localparam int ETYPE_W   = 16;
   localparam int OCTET_W   = 8;
   localparam int KIND_W    = 2;
   localparam int CSR_IDX_W = 4;
   localparam int PROD_W    = SIZE_W + TPB_W;
   localparam int DELAY_W   = PROD_W - FRAC_BITS;
   localparam int QIDX_W    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_W-1:0] KIND_SENT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUEUED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd3;

   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SHAPER_ENABLE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_PER_BYTE = 4'd1;

   localparam logic [SIZE_W-1:0]  MIN_FRAME_SIZE = 16'd40;
   localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [3:0]         IP_VERSION_4   = 4'd4;
   localparam logic [3:0]         MIN_IHL        = 4'd5;
   localparam logic [OCTET_W-1:0] NET_TEN        = 8'd10;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_PASS,
      CMD_SHAPE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type         op;
      logic [NOW_W-1:0]   now;
      logic [TAG_W-1:0]   tag;
      logic [SIZE_W-1:0]  size;
      logic [DELAY_W-1:0] delay;
   } cmd_type;

   typedef struct packed {
      logic [NOW_W-1:0]  due;
      logic [TAG_W-1:0]  tag;
      logic [SIZE_W-1:0] size;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

endpackage

// File: sv/psr_ram.sv
// psr_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module psr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/psr_front.sv
// psr_front: input stage that classifies items and computes the byte delay
// depends on psr_pkg
module psr_front
   import psr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shaper_enable,
   input  logic [TPB_W-1:0]     time_per_byte,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [NOW_W-1:0]     req_now_ms,
   input  logic [TAG_W-1:0]     req_packet_tag,
   input  logic [SIZE_W-1:0]    req_packet_size,
   input  logic [ETYPE_W-1:0]   req_ether_type,
   input  logic [7:0]           req_ip_version_ihl,
   input  logic [OCTET_W-1:0]   req_src_first_octet,
   input  logic [OCTET_W-1:0]   req_dst_first_octet,
   output logic                 push_valid,
   input  logic                 push_ready,
   output cmd_type              push_cmd
);

   logic                 stg_valid_ff, stg_valid_in;
   logic                 stg_op_ff;
   logic [NOW_W-1:0]     stg_now_ff;
   logic [TAG_W-1:0]     stg_tag_ff;
   logic [SIZE_W-1:0]    stg_size_ff;
   logic [ETYPE_W-1:0]   stg_etype_ff;
   logic [7:0]           stg_vihl_ff;
   logic [OCTET_W-1:0]   stg_src_ff;
   logic [OCTET_W-1:0]   stg_dst_ff;
   logic                 accept;
   logic                 internal;
   logic [PROD_W-1:0]    product;

   assign req_ready    = !stg_valid_ff || push_ready;
   assign accept       = req_valid && req_ready;
   assign stg_valid_in = accept || (stg_valid_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
      if (accept) begin
         stg_op_ff    <= req_operation;
         stg_now_ff   <= req_now_ms;
         stg_tag_ff   <= req_packet_tag;
         stg_size_ff  <= req_packet_size;
         stg_etype_ff <= req_ether_type;
         stg_vihl_ff  <= req_ip_version_ihl;
         stg_src_ff   <= req_src_first_octet;
         stg_dst_ff   <= req_dst_first_octet;
      end
   end

   always_comb begin
      internal = (stg_size_ff >= MIN_FRAME_SIZE) &&
                 (stg_etype_ff == ETHERTYPE_IPV4) &&
                 (stg_vihl_ff[7:4] == IP_VERSION_4) &&
                 (stg_vihl_ff[3:0] >= MIN_IHL) &&
                 (stg_src_ff == NET_TEN) && (stg_dst_ff == NET_TEN);
      product = PROD_W'(stg_size_ff) * PROD_W'(time_per_byte);

      if (stg_op_ff == OP_TICK) begin
         push_cmd.op = CMD_TICK;
      end else if (!shaper_enable || internal) begin
         push_cmd.op = CMD_PASS;
      end else begin
         push_cmd.op = CMD_SHAPE;
      end
      push_cmd.now   = stg_now_ff;
      push_cmd.tag   = stg_tag_ff;
      push_cmd.size  = stg_size_ff;
      push_cmd.delay = product[PROD_W-1:FRAC_BITS];
   end

   assign push_valid = stg_valid_ff;

endmodule

// File: sv/psr_cmd_fifo.sv
// psr_cmd_fifo: short command queue between the front and back parts
// depends on psr_pkg
module psr_cmd_fifo
   import psr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
   localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

   cmd_type            entry_ff [CMD_FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(CMD_FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: sv/psr_back.sv
// psr_back: shaper sequencer with the reservation mark and the sorted pending queue
// depends on psr_pkg and psr_ram
module psr_back
   import psr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                shaper_enable,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  cmd_type             pop_cmd,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [TAG_W-1:0]    rsp_out_tag,
   output logic [SIZE_W-1:0]   rsp_out_size,
   output logic                rsp_can_send,
   output logic                rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_INS_RD,
      ST_INS_CHK,
      ST_TK_RD,
      ST_TK_CHK,
      ST_TK_END
   } state_type;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [NOW_W-1:0]    mark_ff, mark_in;
   logic                blocking_ff, blocking_in;
   logic [QIDX_W-1:0]   head_ff, head_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic [QIDX_W-1:0]   idx_ff, idx_in;
   logic [NOW_W-1:0]    ins_due_ff, ins_due_in;
   logic                released_ff, released_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic [SIZE_W-1:0]   rsp_size_ff, rsp_size_in;
   logic                rsp_can_ff, rsp_can_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic                emit;
   logic                ram_wr_en, ram_rd_en;
   logic [QIDX_W-1:0]   ram_wr_addr, ram_rd_addr;
   slot_type            ram_wr_data, ram_rd_data;
   logic [SLOT_W-1:0]   ram_rd_bits;
   logic [NOW_W:0]      sat_sum;
   logic [NOW_W-1:0]    sat_base;
   logic [NOW_W-1:0]    sat_result;
   logic [NOW_W-1:0]    new_mark;
   logic                new_blocking;

   function automatic logic [QIDX_W-1:0] wrap_add(input logic [QIDX_W-1:0] base,
                                                  input logic [QIDX_W-1:0] off);
      logic [QIDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (QIDX_W + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (QIDX_W + 1)'(QUEUE_DEPTH);
      end
      return sum[QIDX_W-1:0];
   endfunction

   psr_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = slot_type'(ram_rd_bits);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign pop_ready   = (state_ff == ST_IDLE);

   // saturating mark update: base is now or the current mark
   always_comb begin
      sat_base   = (!blocking_ff || cmd_ff.now >= mark_ff) ? cmd_ff.now : mark_ff;
      sat_sum    = {1'b0, sat_base} + (NOW_W + 1)'(cmd_ff.delay);
      sat_result = sat_sum[NOW_W] ? {NOW_W{1'b1}} : sat_sum[NOW_W-1:0];
   end

   // mark and blocking after a tick
   always_comb begin
      if (released_ff) begin
         if (count_ff != '0) begin
            new_mark     = ram_rd_data.due;
            new_blocking = 1'b1;
         end else begin
            new_mark     = '0;
            new_blocking = 1'b0;
         end
      end else begin
         new_mark     = mark_ff;
         new_blocking = blocking_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      mark_in     = mark_ff;
      blocking_in = blocking_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      ins_due_in  = ins_due_ff;
      released_in = released_ff;
      emit        = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_tag_in  = rsp_tag_ff;
      rsp_size_in = rsp_size_ff;
      rsp_can_in  = rsp_can_ff;
      rsp_last_in = rsp_last_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wrap_add(head_ff, idx_ff);
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               cmd_in      = pop_cmd;
               released_in = 1'b0;
               state_in    = (pop_cmd.op == CMD_TICK) ? ST_TK_RD : ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_tag_in  = cmd_ff.tag;
               rsp_size_in = cmd_ff.size;
               rsp_can_in  = 1'b0;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
               if (cmd_ff.op == CMD_PASS) begin
                  rsp_kind_in = KIND_SENT;
               end else if (!blocking_ff || cmd_ff.now >= mark_ff) begin
                  rsp_kind_in = KIND_SENT;
                  mark_in     = sat_result;
                  blocking_in = 1'b1;
               end else if (count_ff == QCNT_W'(QUEUE_DEPTH)) begin
                  rsp_kind_in = KIND_DROPPED;
               end else begin
                  rsp_kind_in = KIND_QUEUED;
                  ins_due_in  = mark_ff;
                  mark_in     = sat_result;
                  idx_in      = count_ff[QIDX_W-1:0];
                  state_in    = ST_INS_RD;
               end
            end
         end
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = '{due: ins_due_ff, tag: cmd_ff.tag, size: cmd_ff.size};
               count_in    = count_ff + 1'b1;
               state_in    = ST_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = wrap_add(head_ff, idx_ff - 1'b1);
               state_in    = ST_INS_CHK;
            end
         end
         ST_INS_CHK: begin
            ram_wr_en = 1'b1;
            if (ram_rd_data.due > ins_due_ff) begin
               ram_wr_data = ram_rd_data;
               idx_in      = idx_ff - 1'b1;
               state_in    = ST_INS_RD;
            end else begin
               ram_wr_data = '{due: ins_due_ff, tag: cmd_ff.tag, size: cmd_ff.size};
               count_in    = count_ff + 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_TK_RD: begin
            if (count_ff == '0) begin
               state_in = ST_TK_END;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = head_ff;
               state_in    = ST_TK_CHK;
            end
         end
         ST_TK_CHK: begin
            if (ram_rd_data.due <= cmd_ff.now) begin
               if (out_free) begin
                  emit        = 1'b1;
                  rsp_kind_in = KIND_SENT;
                  rsp_tag_in  = ram_rd_data.tag;
                  rsp_size_in = ram_rd_data.size;
                  rsp_can_in  = 1'b0;
                  rsp_last_in = 1'b0;
                  head_in     = wrap_add(head_ff, QIDX_W'(1));
                  count_in    = count_ff - 1'b1;
                  released_in = 1'b1;
                  state_in    = ST_TK_RD;
               end
            end else begin
               state_in = ST_TK_END;
            end
         end
         ST_TK_END: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_kind_in = KIND_STATUS;
               rsp_tag_in  = '0;
               rsp_size_in = '0;
               rsp_last_in = 1'b1;
               if (!shaper_enable || !new_blocking) begin
                  rsp_can_in = 1'b1;
               end else if (count_ff != '0) begin
                  rsp_can_in = 1'b0;
               end else begin
                  rsp_can_in = (cmd_ff.now >= new_mark);
               end
               mark_in     = new_mark;
               blocking_in = new_blocking;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mark_ff      <= '0;
         blocking_ff  <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         released_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mark_ff      <= mark_in;
         blocking_ff  <= blocking_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         released_ff  <= released_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      ins_due_ff  <= ins_due_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_size_ff <= rsp_size_in;
      rsp_can_ff  <= rsp_can_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_out_tag  = rsp_tag_ff;
   assign rsp_out_size = rsp_size_ff;
   assign rsp_can_send = rsp_can_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// File: sv/packet_rate_shaper.sv
// packet_rate_shaper: top level with configuration registers, front, command queue and back
// depends on psr_pkg, psr_front, psr_cmd_fifo, psr_back
//
//   channel  handshake              payload
//   req      req_valid / req_ready  operation, now_ms, tag, size, header fields
//   rsp      rsp_valid / rsp_ready  kind, out_tag, out_size, can_send, last
//   csr      csr_valid / csr_ready  csr_index, csr_wdata (always ready)
//
// an arrival is decided in the sequencer; when it is queued, each entry moved aside is read
// and written one slot on, then the new one is written (single read port of the queue ram)
// a tick releases each due packet in turn, then emits the status
// the front stage and a 2-entry command queue take items while the back works
// reset clears mark, queue pointers and handshakes; queue ram needs no clearing
module packet_rate_shaper
   import psr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_operation,
   input  logic [NOW_W-1:0]      req_now_ms,
   input  logic [TAG_W-1:0]      req_packet_tag,
   input  logic [SIZE_W-1:0]     req_packet_size,
   input  logic [ETYPE_W-1:0]    req_ether_type,
   input  logic [7:0]            req_ip_version_ihl,
   input  logic [OCTET_W-1:0]    req_src_first_octet,
   input  logic [OCTET_W-1:0]    req_dst_first_octet,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [TAG_W-1:0]      rsp_out_tag,
   output logic [SIZE_W-1:0]     rsp_out_size,
   output logic                  rsp_can_send,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [TPB_W-1:0]      csr_wdata
);

   logic               shaper_enable_ff;
   logic [TPB_W-1:0]   time_per_byte_ff;
   logic               push_valid, push_ready;
   cmd_type            push_cmd;
   logic               pop_valid, pop_ready;
   cmd_type            pop_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shaper_enable_ff <= 1'b0;
         time_per_byte_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SHAPER_ENABLE: shaper_enable_ff <= csr_wdata[0];
            CSR_TIME_PER_BYTE: time_per_byte_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   psr_front u_front (
      .clock               (clock),
      .reset               (reset),
      .shaper_enable       (shaper_enable_ff),
      .time_per_byte       (time_per_byte_ff),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_now_ms          (req_now_ms),
      .req_packet_tag      (req_packet_tag),
      .req_packet_size     (req_packet_size),
      .req_ether_type      (req_ether_type),
      .req_ip_version_ihl  (req_ip_version_ihl),
      .req_src_first_octet (req_src_first_octet),
      .req_dst_first_octet (req_dst_first_octet),
      .push_valid          (push_valid),
      .push_ready          (push_ready),
      .push_cmd            (push_cmd)
   );

   psr_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   psr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .shaper_enable (shaper_enable_ff),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_cmd       (pop_cmd),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_out_tag   (rsp_out_tag),
      .rsp_out_size  (rsp_out_size),
      .rsp_can_send  (rsp_can_send),
      .rsp_last      (rsp_last)
   );

endmodule
